### rtl/rrqs_pkg.sv
// rrqs_pkg: shared types and constants of the round-robin quantum scheduler
// used by rrqs_sub and the top level of the scheduler; depends on nothing
`default_nettype none

package rrqs_pkg;

    localparam int ID_W          = 4;
    localparam int BURST_W       = 16;
    localparam int TIME_W        = 32;
    localparam int QUANTUM_W     = 8;
    localparam int IN_TDATA_W    = 24;
    localparam int IN_TUSER_W    = 1;
    localparam int OUT_TDATA_W   = 200;
    localparam int OUT_TUSER_W   = 3;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    localparam logic [APB_ADDR_W-1:0] ADDR_QUANTUM  = 3'd0;
    localparam logic [QUANTUM_W-1:0]  QUANTUM_RESET = 8'd4;

    // input kind carried in tuser
    localparam logic MODE_ARRIVE = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    typedef struct packed {
        logic              rejected;
        logic              cpu_busy;
        logic              finished;
        logic [ID_W-1:0]   running_id;
        logic [TIME_W-1:0] done_time;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic [TIME_W-1:0] response;
        logic [TIME_W-1:0] switch_total;
        logic [TIME_W-1:0] now;
    } t_result;

endpackage

`default_nettype wire

### rtl/rrqs_ram.sv
// rrqs_ram: generic single-write, single-read ram with registered read data
// standalone, no package needed
`default_nettype none

module rrqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/rrqs_sub.sv
// rrqs_sub: shared 32-bit subtract unit with a registered difference
// depends on rrqs_pkg for the time width
`default_nettype none

module rrqs_sub
    import rrqs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic [TIME_W-1:0] i_a,
    input  wire logic [TIME_W-1:0] i_b,
    output logic      [TIME_W-1:0] o_diff
);

    logic [TIME_W-1:0] r_diff;

    // wraps modulo 2^32 like every time counter of the scheduler
    always_ff @(posedge i_clk) begin
        r_diff <= i_a - i_b;
    end

    assign o_diff = r_diff;

endmodule

`default_nettype wire

### rtl/round_robin_quantum_scheduler.sv
// round_robin_quantum_scheduler: top level, sequencer, ready ring and process tables
// depends on rrqs_pkg, rrqs_ram and rrqs_sub
`default_nettype none

// Tick-driven round-robin scheduler. Each input item is either an arrival
// (tuser 0) or a scheduler tick (tuser 1) and yields exactly one result item.
// Items run one at a time through a small sequencer over the ready ring and
// the per-process tables, which are single-port-read rams with registered
// read data; turnaround, waiting and response come from one shared 32-bit
// subtractor used for each in turn. s_tready is high only while the sequencer
// is idle and rises in the cycle the result is offered, so a new item is taken
// only once the last one's result is offered; a result waiting on m_tready does
// not hold it up until the next result is ready. The quantum register lies at
// byte address 0 and should be written only while the block is idle.
module round_robin_quantum_scheduler
    import rrqs_pkg::*;
#(
    parameter int MAX_PROCS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // input stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // proc_id[3:0], burst[19:4], zero pad
    input  wire logic [IN_TUSER_W-1:0]  s_tuser,   // mode[0]
    // result stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [OUT_TDATA_W-1:0] m_tdata,   // running_id[3:0], done_time[35:4],
                                                   // turnaround[67:36], waiting[99:68],
                                                   // response[131:100], switch_total[163:132],
                                                   // now[195:164], zero pad
    output logic      [OUT_TUSER_W-1:0] m_tuser,   // rejected[0], cpu_busy[1], finished[2]
    // configuration
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    output logic      [APB_DATA_W-1:0]  prdata,
    output logic                        pready
);

    localparam int NUM_IDS = (MAX_PROCS < (1 << ID_W)) ? MAX_PROCS : (1 << ID_W);
    localparam int TAB_AW  = $clog2(NUM_IDS);
    localparam int RING_AW = $clog2(MAX_PROCS);
    localparam int CNT_W   = $clog2(MAX_PROCS + 1);

    localparam logic [RING_AW-1:0] RING_LAST  = RING_AW'(MAX_PROCS - 1);
    localparam logic [CNT_W-1:0]   RING_FULL  = CNT_W'(MAX_PROCS);
    localparam logic [8:0]         PROCS_LIM  = 9'(MAX_PROCS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ARRIVE,
        S_TICK,
        S_POP,
        S_RUN,
        S_DEC,
        S_WAIT,
        S_RESP,
        S_FIN,
        S_DONE
    } t_state;

    t_state                 r_state;
    logic                   r_mode;
    logic [ID_W-1:0]        r_id;
    logic [BURST_W-1:0]     r_burst;
    logic [QUANTUM_W-1:0]   r_quantum;
    logic [RING_AW-1:0]     r_head;
    logic [RING_AW-1:0]     r_tail;
    logic [CNT_W-1:0]       r_count;
    logic [NUM_IDS-1:0]     r_started;
    logic [NUM_IDS-1:0]     r_active;
    logic                   r_holder_valid;
    logic [ID_W-1:0]        r_holder;
    logic [QUANTUM_W-1:0]   r_slice;
    logic                   r_last_valid;
    logic [ID_W-1:0]        r_last;
    logic [TIME_W-1:0]      r_switch;
    logic [TIME_W-1:0]      r_tick;
    t_result                r_res;
    t_result                r_out;
    t_result                n_out;
    logic                   r_mvalid;

    // ram ports
    logic                   ring_we;
    logic [ID_W-1:0]        ring_wdata;
    logic [ID_W-1:0]        ring_rdata;
    logic                   arr_we;
    logic [TIME_W-1:0]      arr_rdata;
    logic                   bst_we;
    logic [BURST_W-1:0]     bst_rdata;
    logic                   left_we;
    logic [TAB_AW-1:0]      left_waddr;
    logic [BURST_W-1:0]     left_wdata;
    logic [BURST_W-1:0]     left_rdata;
    logic                   first_we;
    logic [TIME_W-1:0]      first_rdata;
    logic [TIME_W-1:0]      sub_a;
    logic [TIME_W-1:0]      sub_b;
    logic [TIME_W-1:0]      sub_q;

    logic                   in_accept;
    logic                   cfg_write;
    logic                   id_ok;
    logic                   ring_full;
    logic                   arrive_reject;
    logic                   out_free;
    logic                   out_load;
    logic [BURST_W-1:0]     left_dec;
    logic [QUANTUM_W-1:0]   slice_inc;
    logic [TIME_W-1:0]      fin_time;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (r_state == S_IDLE);
    assign out_free  = !r_mvalid || m_tready;
    assign out_load  = (r_state == S_DONE) && out_free;

    assign id_ok         = ({5'd0, r_id} < PROCS_LIM);
    assign ring_full     = (r_count == RING_FULL);
    assign arrive_reject = (r_burst == '0) || !id_ok || ring_full ||
                           r_active[r_id[TAB_AW-1:0]];

    assign left_dec  = left_rdata - BURST_W'(1);
    assign slice_inc = r_slice + QUANTUM_W'(1);
    assign fin_time  = r_tick + TIME_W'(1);

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_QUANTUM);
    assign prdata    = (paddr == ADDR_QUANTUM) ? {{(APB_DATA_W-QUANTUM_W){1'b0}}, r_quantum}
                                               : '0;

    // result as it leaves, with the running totals filled in
    always_comb begin
        n_out              = r_res;
        n_out.switch_total = r_switch;
        n_out.now          = r_tick;
    end

    // ram and subtractor control
    always_comb begin
        ring_we    = 1'b0;
        ring_wdata = r_id;
        arr_we     = 1'b0;
        bst_we     = 1'b0;
        left_we    = 1'b0;
        left_waddr = r_holder[TAB_AW-1:0];
        left_wdata = left_dec;
        first_we   = 1'b0;
        sub_a      = fin_time;
        sub_b      = arr_rdata;
        case (r_state)
            S_ARRIVE: begin
                if (!arrive_reject) begin
                    ring_we    = 1'b1;
                    arr_we     = 1'b1;
                    bst_we     = 1'b1;
                    left_we    = 1'b1;
                    left_waddr = r_id[TAB_AW-1:0];
                    left_wdata = r_burst;
                end
            end
            S_POP: begin
                first_we = !r_started[ring_rdata[TAB_AW-1:0]];
            end
            S_DEC: begin
                left_we = 1'b1;
                // preempted holder goes back to the tail
                if (left_dec != '0 && slice_inc == r_quantum && !ring_full) begin
                    ring_we    = 1'b1;
                    ring_wdata = r_holder;
                end
            end
            S_WAIT: begin
                sub_a = sub_q;
                sub_b = {{(TIME_W-BURST_W){1'b0}}, bst_rdata};
            end
            S_RESP: begin
                sub_a = first_rdata;
                sub_b = arr_rdata;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_quantum      <= QUANTUM_RESET;
            r_head         <= '0;
            r_tail         <= '0;
            r_count        <= '0;
            r_started      <= '0;
            r_active       <= '0;
            r_holder_valid <= 1'b0;
            r_holder       <= '0;
            r_slice        <= '0;
            r_last_valid   <= 1'b0;
            r_last         <= '0;
            r_switch       <= '0;
            r_tick         <= '0;
            r_mvalid       <= 1'b0;
        end else begin
            if (cfg_write) begin
                r_quantum <= pwdata[QUANTUM_W-1:0];
            end
            if (out_load) begin
                r_mvalid <= 1'b1;
            end else if (m_tready) begin
                r_mvalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_mode  <= s_tuser[0];
                        r_id    <= s_tdata[ID_W-1:0];
                        r_burst <= s_tdata[ID_W+BURST_W-1:ID_W];
                        r_res   <= '0;
                        r_state <= (s_tuser[0] == MODE_TICK) ? S_TICK : S_ARRIVE;
                    end
                end
                S_ARRIVE: begin
                    if (arrive_reject) begin
                        r_res.rejected <= 1'b1;
                    end else begin
                        r_started[r_id[TAB_AW-1:0]] <= 1'b0;
                        r_active[r_id[TAB_AW-1:0]]  <= 1'b1;
                        r_tail  <= (r_tail == RING_LAST) ? '0 : r_tail + RING_AW'(1);
                        r_count <= r_count + CNT_W'(1);
                    end
                    r_state <= S_DONE;
                end
                S_TICK: begin
                    if (!r_holder_valid && r_count != '0) begin
                        r_state <= S_POP;
                    end else if (r_holder_valid) begin
                        r_state <= S_RUN;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_POP: begin
                    if (r_last_valid && r_last != ring_rdata) begin
                        r_switch <= r_switch + TIME_W'(1);
                    end
                    r_holder       <= ring_rdata;
                    r_holder_valid <= 1'b1;
                    r_slice        <= '0;
                    r_last         <= ring_rdata;
                    r_last_valid   <= 1'b1;
                    r_started[ring_rdata[TAB_AW-1:0]] <= 1'b1;
                    r_head  <= (r_head == RING_LAST) ? '0 : r_head + RING_AW'(1);
                    r_count <= r_count - CNT_W'(1);
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    // table reads at the holder are in flight
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    r_res.cpu_busy   <= 1'b1;
                    r_res.running_id <= r_holder;
                    r_slice          <= slice_inc;
                    if (left_dec == '0) begin
                        r_res.finished    <= 1'b1;
                        r_res.done_time   <= fin_time;
                        r_active[r_holder[TAB_AW-1:0]] <= 1'b0;
                        r_holder_valid    <= 1'b0;
                        r_state           <= S_WAIT;
                    end else begin
                        if (slice_inc == r_quantum) begin
                            r_holder_valid <= 1'b0;
                            if (!ring_full) begin
                                r_tail  <= (r_tail == RING_LAST) ? '0
                                                                 : r_tail + RING_AW'(1);
                                r_count <= r_count + CNT_W'(1);
                            end
                        end
                        r_state <= S_DONE;
                    end
                end
                S_WAIT: begin
                    r_res.turnaround <= sub_q;
                    r_state          <= S_RESP;
                end
                S_RESP: begin
                    r_res.waiting <= sub_q;
                    r_state       <= S_FIN;
                end
                S_FIN: begin
                    r_res.response <= sub_q;
                    r_state        <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out <= n_out;
                        if (r_mode == MODE_TICK) begin
                            r_tick <= fin_time;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = r_mvalid;
    assign m_tuser  = {r_out.finished, r_out.cpu_busy, r_out.rejected};
    assign m_tdata  = {4'd0, r_out.now, r_out.switch_total, r_out.response, r_out.waiting,
                       r_out.turnaround, r_out.done_time, r_out.running_id};

    rrqs_ram #(.WIDTH(ID_W), .DEPTH(MAX_PROCS)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_tail),
        .i_wdata (ring_wdata),
        .i_raddr (r_head),
        .o_rdata (ring_rdata)
    );

    rrqs_ram #(.WIDTH(TIME_W), .DEPTH(NUM_IDS)) u_arrive_at (
        .i_clk   (i_clk),
        .i_we    (arr_we),
        .i_waddr (r_id[TAB_AW-1:0]),
        .i_wdata (r_tick),
        .i_raddr (r_holder[TAB_AW-1:0]),
        .o_rdata (arr_rdata)
    );

    rrqs_ram #(.WIDTH(BURST_W), .DEPTH(NUM_IDS)) u_burst_len (
        .i_clk   (i_clk),
        .i_we    (bst_we),
        .i_waddr (r_id[TAB_AW-1:0]),
        .i_wdata (r_burst),
        .i_raddr (r_holder[TAB_AW-1:0]),
        .o_rdata (bst_rdata)
    );

    rrqs_ram #(.WIDTH(BURST_W), .DEPTH(NUM_IDS)) u_left_ticks (
        .i_clk   (i_clk),
        .i_we    (left_we),
        .i_waddr (left_waddr),
        .i_wdata (left_wdata),
        .i_raddr (r_holder[TAB_AW-1:0]),
        .o_rdata (left_rdata)
    );

    rrqs_ram #(.WIDTH(TIME_W), .DEPTH(NUM_IDS)) u_first_run_at (
        .i_clk   (i_clk),
        .i_we    (first_we),
        .i_waddr (ring_rdata[TAB_AW-1:0]),
        .i_wdata (r_tick),
        .i_raddr (r_holder[TAB_AW-1:0]),
        .o_rdata (first_rdata)
    );

    rrqs_sub u_sub (
        .i_clk  (i_clk),
        .i_a    (sub_a),
        .i_b    (sub_b),
        .o_diff (sub_q)
    );

endmodule

`default_nettype wire

### tb/round_robin_quantum_scheduler_tb.sv
// round_robin_quantum_scheduler_tb: self-checking bench for the round-robin scheduler,
// stream driver and result monitor with an item-level process scheduler predictor
// depends on rrqs_pkg and round_robin_quantum_scheduler
module round_robin_quantum_scheduler_tb;
    import rrqs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPROC        = 16;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int PHASE_ITEMS  = 265;

    typedef struct packed {
        logic               mode;
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] burst;
    } t_sched_item;

    logic                    i_clk;
    logic                    i_rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata = '0;  // proc_id[3:0], burst[19:4], zero pad
    logic [IN_TUSER_W-1:0]   s_tuser = '0;  // mode[0]
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;       // running_id, done_time, turnaround, waiting,
                                            // response, switch_total, now, zero pad
    logic [OUT_TUSER_W-1:0]  m_tuser;       // rejected[0], cpu_busy[1], finished[2]
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr = '0;
    logic [APB_DATA_W-1:0]   pwdata = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    round_robin_quantum_scheduler #(.MAX_PROCS(NPROC)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // scheduler state as the predictor sees it
    logic [ID_W-1:0]      ring_q [NPROC];
    logic [ID_W-1:0]      rd_ptr = '0;
    logic [ID_W-1:0]      wr_ptr = '0;
    int unsigned          ring_fill = 0;
    logic [TIME_W-1:0]    arr_t [NPROC];
    logic [BURST_W-1:0]   need [NPROC];
    logic [BURST_W-1:0]   remain [NPROC];
    logic [TIME_W-1:0]    first_t [NPROC];
    bit                   started [NPROC] = '{default: 1'b0};
    bit                   active [NPROC] = '{default: 1'b0};
    bit                   on_cpu = 1'b0;
    logic [ID_W-1:0]      holder = '0;
    logic [QUANTUM_W-1:0] used = '0;
    bit                   ran_before = 1'b0;
    logic [ID_W-1:0]      prev_ran = '0;
    logic [TIME_W-1:0]    switches = '0;
    logic [TIME_W-1:0]    clock_now = '0;
    logic [QUANTUM_W-1:0] slice_limit = QUANTUM_RESET;

    t_sched_item pending_items[$];
    t_result     expected_results[$];

    int  fail_count = 0;
    int  items_seen = 0;
    int  refused = 0;
    int  completions = 0;
    int  idle_ticks = 0;
    int  quantum_writes = 0;
    bit  item_taken = 1'b0;
    bit  tx_gaps_on = 1'b1;
    bit  rx_stalls_on = 1'b1;
    int  tx_gap = 0;
    int  rx_hold = 0;

    function automatic t_result sched_step(logic mode, logic [ID_W-1:0] id,
                                           logic [BURST_W-1:0] burst);
        t_result           r;
        logic [ID_W-1:0]   h;
        logic [TIME_W-1:0] fin;
        r = '0;
        r.now = clock_now;
        if (mode == MODE_ARRIVE) begin
            if (burst == '0 || ring_fill >= NPROC || active[id]) begin
                r.rejected = 1'b1;
            end else begin
                arr_t[id]   = clock_now;
                need[id]    = burst;
                remain[id]  = burst;
                started[id] = 1'b0;
                active[id]  = 1'b1;
                ring_q[wr_ptr] = id;
                wr_ptr++;
                ring_fill++;
            end
        end else begin
            // idle cpu takes the head of the ready ring
            if (!on_cpu && ring_fill > 0) begin
                h = ring_q[rd_ptr];
                rd_ptr++;
                ring_fill--;
                if (ran_before && prev_ran != h) switches++;
                holder = h;
                on_cpu = 1'b1;
                used   = '0;
                if (!started[h]) begin
                    started[h] = 1'b1;
                    first_t[h] = clock_now;
                end
                prev_ran   = h;
                ran_before = 1'b1;
            end
            if (on_cpu) begin
                h = holder;
                r.cpu_busy   = 1'b1;
                r.running_id = h;
                remain[h]--;
                used++;
                if (remain[h] == '0) begin
                    fin = clock_now + 1;
                    r.finished    = 1'b1;
                    r.done_time   = fin;
                    r.turnaround  = fin - arr_t[h];
                    r.waiting     = r.turnaround - TIME_W'(need[h]);
                    r.response    = first_t[h] - arr_t[h];
                    active[h] = 1'b0;
                    on_cpu    = 1'b0;
                end else if (used == slice_limit) begin
                    // slice used up, back to the tail (quantum 0 wraps to 256)
                    ring_q[wr_ptr] = h;
                    wr_ptr++;
                    ring_fill++;
                    on_cpu = 1'b0;
                end
            end
            clock_now++;
        end
        r.switch_total = switches;
        return r;
    endfunction

    function automatic string fmt_result(t_result r);
        return $sformatf({"rej=%0d busy=%0d id=%0d fin=%0d ft=%0d ta=%0d wt=%0d rs=%0d",
                          " sw=%0d now=%0d"},
                         r.rejected, r.cpu_busy, r.running_id, r.finished, r.done_time,
                         r.turnaround, r.waiting, r.response, r.switch_total, r.now);
    endfunction

    task automatic report_failure(string msg);
        fail_count++;
        if (fail_count <= 10) $display("%t mismatch: %s", $realtime, msg);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 2);
        if (r < 92) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // result check and prediction, both at the rising edge
    t_result got;
    t_result want;
    string   bad;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                got.rejected     = m_tuser[0];
                got.cpu_busy     = m_tuser[1];
                got.finished     = m_tuser[2];
                got.running_id   = m_tdata[3:0];
                got.done_time    = m_tdata[35:4];
                got.turnaround   = m_tdata[67:36];
                got.waiting      = m_tdata[99:68];
                got.response     = m_tdata[131:100];
                got.switch_total = m_tdata[163:132];
                got.now          = m_tdata[195:164];
                if (expected_results.size() == 0) begin
                    report_failure({"result with nothing pending: ", fmt_result(got)});
                end else begin
                    want = expected_results.pop_front();
                    bad = "";
                    if (got.rejected != want.rejected) bad = {bad, " rejected"};
                    if (got.cpu_busy != want.cpu_busy) bad = {bad, " cpu_busy"};
                    if (got.running_id != want.running_id) bad = {bad, " running_id"};
                    if (got.finished != want.finished) bad = {bad, " finished"};
                    if (got.done_time != want.done_time) bad = {bad, " done_time"};
                    if (got.turnaround != want.turnaround) bad = {bad, " turnaround"};
                    if (got.waiting != want.waiting) bad = {bad, " waiting"};
                    if (got.response != want.response) bad = {bad, " response"};
                    if (got.switch_total != want.switch_total) bad = {bad, " switch_total"};
                    if (got.now != want.now) bad = {bad, " now"};
                    if (bad != "")
                        report_failure({"field", bad, "\n  exp ", fmt_result(want),
                                        "\n  got ", fmt_result(got)});
                end
            end
            if (s_tvalid && s_tready) begin
                want = sched_step(s_tuser[0], s_tdata[3:0], s_tdata[19:4]);
                expected_results.push_back(want);
                items_seen++;
                if (want.rejected) refused++;
                if (want.finished) completions++;
                if (s_tuser[0] == MODE_TICK && !want.cpu_busy) idle_ticks++;
                item_taken = 1'b1;
            end
        end
    end

    // stream driver
    t_sched_item cur;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || item_taken) begin
            item_taken = 1'b0;
            if (tx_gap > 0) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                cur = pending_items.pop_front();
                s_tdata  <= {4'b0000, cur.burst, cur.id};
                s_tuser  <= cur.mode;
                s_tvalid <= 1'b1;
                tx_gap = (tx_gaps_on && $urandom_range(0, 99) < 40) ? pick_gap() : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (rx_stalls_on && $urandom_range(0, 99) < 25) rx_hold = pick_gap();
        end
    end

    task automatic apb_access(input bit wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_quantum();
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b0, ADDR_QUANTUM, '0, rd);
        if (rd != APB_DATA_W'(slice_limit))
            report_failure($sformatf("quantum read back %0d, expected %0d", rd, slice_limit));
    endtask

    task automatic set_quantum(input logic [QUANTUM_W-1:0] q);
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b1, ADDR_QUANTUM, APB_DATA_W'(q), rd);
        slice_limit = q;
        quantum_writes++;
        check_quantum();
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic add_item(input logic mode, input int id, input int burst);
        t_sched_item it;
        it.mode  = mode;
        it.id    = ID_W'(id);
        it.burst = BURST_W'(burst);
        pending_items.push_back(it);
    endtask

    task automatic add_ticks(input int n);
        repeat (n) add_item(MODE_TICK, 0, 0);
    endtask

    // mostly small bursts so processes keep finishing; id 15 holds a long job,
    // so arrivals on it are always refused and carry full-width bursts
    task automatic add_random(input int n);
        int r;
        int id;
        int b;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 17) begin
                id = ($urandom_range(0, 9) == 0) ? 15 : $urandom_range(0, 14);
                r = $urandom_range(0, 99);
                if (id == 15) b = $urandom_range(0, 65535);
                else if (r < 5) b = 0;
                else if (r < 78) b = $urandom_range(1, 4);
                else if (r < 97) b = $urandom_range(5, 16);
                else b = $urandom_range(17, 300);
                add_item(MODE_ARRIVE, id, b);
            end else if (r < 20) begin
                // noise: tick with junk in the arrival fields
                add_item(MODE_TICK, $urandom_range(0, 15), $urandom_range(0, 65535));
            end else begin
                add_item(MODE_TICK, 0, 0);
            end
        end
    endtask

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("[round_robin_quantum_scheduler] ERROR");
        $finish;
    end

    initial begin
        logic [QUANTUM_W-1:0] q_list [6];
        q_list[0] = 8'd1;
        q_list[1] = 8'd255;
        q_list[2] = 8'd0;
        q_list[3] = QUANTUM_W'($urandom_range(2, 254));
        q_list[4] = 8'd2;
        q_list[5] = QUANTUM_W'($urandom_range(1, 255));

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        check_quantum();

        // directed: idle tick, refusals, long job, completion and re-arrival
        add_ticks(1);
        add_item(MODE_ARRIVE, 0, 0);
        add_item(MODE_ARRIVE, 0, 3);
        add_item(MODE_ARRIVE, 0, 7);
        add_item(MODE_ARRIVE, 15, 16'hFFFF);
        add_item(MODE_ARRIVE, 5, 1);
        add_item(MODE_ARRIVE, 10, 2);
        add_ticks(8);
        add_item(MODE_ARRIVE, 0, 1);
        add_ticks(8);
        wait_drained();

        for (int p = 0; p < 6; p++) begin
            tx_gaps_on   = (p != 2);
            rx_stalls_on = (p != 2 && p != 4);
            repeat (4) @(negedge i_clk);
            set_quantum(q_list[p]);
            add_random(PHASE_ITEMS);
            wait_drained();
        end

        repeat (20) @(negedge i_clk);
        fail_count += expected_results.size();
        $display("ran %0d items over %0d quantum settings: %0d refused arrivals, %0d completions,",
                 items_seen, quantum_writes, refused, completions);
        $display("%0d idle ticks, %0d context switches, %0d ticks elapsed",
                 idle_ticks, switches, clock_now);
        if (fail_count == 0) begin
            $display("[round_robin_quantum_scheduler] OK");
        end else begin
            $display("[round_robin_quantum_scheduler] ERROR");
        end
        $finish;
    end

endmodule

### sim.f
rtl/rrqs_pkg.sv
rtl/rrqs_ram.sv
rtl/rrqs_sub.sv
rtl/round_robin_quantum_scheduler.sv
tb/round_robin_quantum_scheduler_tb.sv
